// File: rtl/core/ifba_pkg.sv
`default_nettype none

package ifba_pkg;

   localparam int BIN_SIZE_DEFAULT = 5000;
   localparam int MAX_SPAN_DEFAULT = 63;

   localparam int POS_W = 31;
   localparam int VAL_W = 17;
   localparam int SUM_W = 32;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 48;

   localparam logic [SUM_W-1:0] AVG_MAX = 32'd65536;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RS_GO,
      ST_RS_WAIT,
      ST_RE_GO,
      ST_RE_WAIT,
      ST_JUMP,
      ST_LO,
      ST_CHECK,
      ST_MUL_CROSS,
      ST_ACC_CROSS,
      ST_ADVANCE,
      ST_MUL_FINAL,
      ST_ACC_FINAL,
      ST_EDIV_GO,
      ST_EDIV_WAIT,
      ST_EOUT,
      ST_FLUSH_DONE
   } state_type;

   typedef enum logic [1:0] {
      DIV_START,
      DIV_STOP,
      DIV_SUM
   } div_sel_type;

   typedef enum logic [1:0] {
      EM_JUMP,
      EM_CROSS,
      EM_FLUSH
   } emit_mode_type;

   typedef enum logic {
      MUL_CROSS,
      MUL_FINAL
   } mul_sel_type;

   typedef struct packed {
      logic          latch_in;
      logic          div_go;
      div_sel_type   div_sel;
      logic          load_rs;
      logic          load_re;
      logic          jump_cur;
      logic          load_lo;
      logic          mul_go;
      mul_sel_type   mul_sel;
      logic          acc;
      logic          emit;
      emit_mode_type emit_mode;
      logic          advance;
      logic          clear_stream;
   } cmd_type;

   typedef struct packed {
      logic kind;
      logic div_done;
      logic cur_lt_rs;
      logic pending;
      logic re_gt_cur;
      logic cross_err;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/core/interval_to_fixed_bin_weighted_average.sv
`default_nettype none

// Rebins a sorted stream of weighted intervals into fixed bins of BIN_SIZE positions and
// emits, for every bin that received an entry, its start and the length-weighted mean value
// (Q1.16, saturated at 1.0). A flush item emits the open bin and starts a new stream. One
// item is worked on at a time, and all divisions by the bin size share one pipelined
// reciprocal multiplier that returns quotient and remainder. For an interval item, two
// divisions find the bins of its start and stop, and the input stays busy longer when it
// first closes a pending bin, for each bin boundary it crosses and while the result register
// is stalled, and less when the interval is cut off at the span limit. A flush stays busy
// longer when it emits a result.
module interval_to_fixed_bin_weighted_average
   import ifba_pkg::*;
#(
   parameter int BIN_SIZE = BIN_SIZE_DEFAULT,
   parameter int MAX_SPAN = MAX_SPAN_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // interval_start, interval_stop, value, zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // kind
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // bin_start, average
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic                       rsp_tlast,
   // span_error
   output logic                       rsp_tuser
);

   cmd_type    cmd;
   status_type status;

   ifba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   ifba_datapath #(
      .BIN_SIZE (BIN_SIZE),
      .MAX_SPAN (MAX_SPAN)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: rtl/core/ifba_div.sv
`default_nettype none

module ifba_div
   import ifba_pkg::*;
#(
   parameter int DIVISOR = BIN_SIZE_DEFAULT,
   parameter int RW      = $clog2(BIN_SIZE_DEFAULT) + 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             go,
   input  wire logic [SUM_W-1:0] dividend,
   output logic                  done,
   output logic      [SUM_W-1:0] quotient,
   output logic      [RW-1:0]    remainder
);

   // The quotient comes from a multiplication by the rounded-up reciprocal of the divisor,
   // which is exact for every 32-bit dividend. The multiplication is split into two halves.
   localparam int LO_W    = 17;
   localparam int HI_W    = SUM_W + 1 - LO_W;
   localparam int PLO_W   = SUM_W + LO_W;
   localparam int PHI_W   = SUM_W + HI_W;
   localparam int PROD_W  = 2 * SUM_W + 1;
   localparam int RECIP_W = SUM_W + 1;
   localparam int SHIFT   = SUM_W + $clog2(DIVISOR);
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
   localparam logic [RW-1:0]      DIV_C   = RW'(DIVISOR);

   logic [SUM_W-1:0]  x_ff, x_in;
   logic [PLO_W-1:0]  plo_ff, plo_in;
   logic [PHI_W-1:0]  phi_ff, phi_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic              mul_ff, mul_in;
   logic              add_ff, add_in;
   logic              sub_ff, sub_in;
   logic              done_ff, done_in;
   logic [PROD_W-1:0] prod;
   logic [RW-1:0]     back;

   always_comb begin
      x_in    = x_ff;
      plo_in  = plo_ff;
      phi_in  = phi_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      mul_in  = go;
      add_in  = mul_ff;
      sub_in  = add_ff;
      done_in = sub_ff;
      prod    = {phi_ff, {LO_W{1'b0}}} + PROD_W'(plo_ff);
      back    = quo_ff[RW-1:0] * DIV_C;
      if (go) begin
         x_in = dividend;
      end
      if (mul_ff) begin
         plo_in = PLO_W'(x_ff) * PLO_W'(RECIP_C[LO_W-1:0]);
         phi_in = PHI_W'(x_ff) * PHI_W'(RECIP_C[RECIP_W-1:LO_W]);
      end
      if (add_ff) begin
         quo_in = SUM_W'(prod >> SHIFT);
      end
      if (sub_ff) begin
         rem_in = x_ff[RW-1:0] - back;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         add_ff  <= 1'b0;
         sub_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         add_ff  <= add_in;
         sub_ff  <= sub_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < DIV_C))
      else $error("Divider remainder is not below the divisor.");

   a_quotient_exact: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ((64'(quo_ff) * 64'(DIVISOR) + 64'(rem_ff)) == 64'(x_ff)))
      else $error("Divider quotient and remainder do not rebuild the dividend.");

   a_go_when_idle: assert property (@(posedge clock) disable iff (reset)
      go |-> !(mul_ff || add_ff || sub_ff))
      else $error("Divider started while a division was still in progress.");
`endif

endmodule

`default_nettype wire

// File: rtl/core/ifba_datapath.sv
`default_nettype none

module ifba_datapath
   import ifba_pkg::*;
#(
   parameter int BIN_SIZE = BIN_SIZE_DEFAULT,
   parameter int MAX_SPAN = MAX_SPAN_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic                       rsp_tlast,
   output logic                       rsp_tuser
);

   localparam int LW    = $clog2(BIN_SIZE) + 1;
   localparam int CW    = $clog2(MAX_SPAN + 1);
   localparam int PW    = VAL_W + LW;
   localparam int ACC_W = ((PW > SUM_W) ? PW : SUM_W) + 1;
   localparam logic [SUM_W-1:0] BIN_C = SUM_W'(BIN_SIZE);

   logic [POS_W-1:0] start_ff, start_in;
   logic [POS_W-1:0] stop_ff, stop_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic             kind_ff, kind_in;
   logic [POS_W-1:0] rs_ff, rs_in;
   logic [POS_W-1:0] re_ff, re_in;
   logic [POS_W-1:0] lo_ff, lo_in;
   logic [PW-1:0]    prod_ff, prod_in;
   logic [POS_W-1:0] cur_ff, cur_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             pending_ff, pending_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] rsp_bin_ff, rsp_bin_in;
   logic [VAL_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_err_ff, rsp_err_in;

   logic [SUM_W-1:0] dividend;
   logic             div_done;
   logic [SUM_W-1:0] quotient;
   logic [LW-1:0]    remainder;
   logic [SUM_W-1:0] hi;
   logic             more;
   logic             at_limit;
   logic [SUM_W-1:0] diff;
   logic [LW-1:0]    len;
   logic [ACC_W-1:0] acc_sum;
   logic [VAL_W-1:0] avg_sat;

   always_comb begin
      case (cmd.div_sel)
         DIV_START: dividend = {1'b0, start_ff};
         DIV_STOP:  dividend = {1'b0, stop_ff};
         DIV_SUM:   dividend = sum_ff;
         default:   dividend = sum_ff;
      endcase
   end

   ifba_div #(
      .DIVISOR (BIN_SIZE),
      .RW      (LW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (cmd.div_go),
      .dividend  (dividend),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   always_comb begin
      hi       = {1'b0, cur_ff} + BIN_C;
      more     = (hi < {1'b0, re_ff});
      at_limit = (count_ff == CW'(MAX_SPAN - 1));
      if (cmd.mul_sel == MUL_CROSS) begin
         diff = hi - {1'b0, lo_ff};
      end else begin
         diff = (stop_ff > lo_ff) ? ({1'b0, stop_ff} - {1'b0, lo_ff}) : '0;
      end
      len     = diff[LW-1:0];
      prod_in = PW'(val_ff) * PW'(len);
      acc_sum = ACC_W'(sum_ff) + ACC_W'(prod_ff);
      avg_sat = (quotient > AVG_MAX) ? AVG_MAX[VAL_W-1:0] : quotient[VAL_W-1:0];
   end

   always_comb begin
      start_in     = start_ff;
      stop_in      = stop_ff;
      val_in       = val_ff;
      kind_in      = kind_ff;
      rs_in        = rs_ff;
      re_in        = re_ff;
      lo_in        = lo_ff;
      cur_in       = cur_ff;
      sum_in       = sum_ff;
      pending_in   = pending_ff;
      count_in     = count_ff;
      rsp_bin_in   = rsp_bin_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (cmd.latch_in) begin
         start_in = req_tdata[POS_W-1:0];
         stop_in  = req_tdata[2*POS_W-1:POS_W];
         val_in   = req_tdata[2*POS_W+VAL_W-1:2*POS_W];
         kind_in  = req_tuser;
         count_in = '0;
      end
      if (cmd.load_rs) begin
         rs_in = start_ff - POS_W'(remainder);
      end
      if (cmd.load_re) begin
         re_in = stop_ff - POS_W'(remainder);
      end
      if (cmd.jump_cur) begin
         cur_in = rs_ff;
      end
      if (cmd.load_lo) begin
         lo_in = (start_ff > cur_ff) ? start_ff : cur_ff;
      end
      if (cmd.acc) begin
         sum_in     = (acc_sum > ACC_W'({SUM_W{1'b1}})) ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
         pending_in = 1'b1;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_bin_in   = cur_ff;
         rsp_avg_in   = avg_sat;
         case (cmd.emit_mode)
            EM_JUMP: begin
               rsp_last_in = !(re_ff > rs_ff);
               rsp_err_in  = 1'b0;
            end
            EM_CROSS: begin
               rsp_last_in = !more || at_limit;
               rsp_err_in  = more && at_limit;
            end
            EM_FLUSH: begin
               rsp_last_in = 1'b1;
               rsp_err_in  = 1'b0;
            end
            default: begin
               rsp_last_in = 1'b1;
               rsp_err_in  = 1'b0;
            end
         endcase
         sum_in     = '0;
         pending_in = 1'b0;
      end
      if (cmd.advance) begin
         cur_in   = hi[POS_W-1:0];
         lo_in    = hi[POS_W-1:0];
         count_in = count_ff + 1'b1;
      end
      if (cmd.clear_stream) begin
         cur_in     = '0;
         sum_in     = '0;
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         sum_ff       <= '0;
         pending_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         sum_ff       <= sum_in;
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      stop_ff     <= stop_in;
      val_ff      <= val_in;
      kind_ff     <= kind_in;
      rs_ff       <= rs_in;
      re_ff       <= re_in;
      lo_ff       <= lo_in;
      rsp_bin_ff  <= rsp_bin_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
      if (cmd.mul_go) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      status.kind      = kind_ff;
      status.div_done  = div_done;
      status.cur_lt_rs = (cur_ff < rs_ff);
      status.pending   = pending_ff;
      status.re_gt_cur = (re_ff > cur_ff);
      status.cross_err = more && at_limit;
      status.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_avg_ff, rsp_bin_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

`ifndef SYNTHESIS
   a_error_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> rsp_last_ff)
      else $error("A truncated interval flagged a result that is not its last.");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SPAN))
      else $error("Crossing count ran past the span limit.");

   a_avg_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({15'd0, rsp_avg_ff} <= AVG_MAX))
      else $error("Average exceeds its saturation limit.");
`endif

endmodule

`default_nettype wire

// File: rtl/core/ifba_ctrl.sv
`default_nettype none

module ifba_ctrl
   import ifba_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output cmd_type         cmd,
   input  wire status_type status
);

   state_type     state_ff, state_in;
   state_type     ret_ff, ret_in;
   emit_mode_type mode_ff, mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         mode_ff  <= EM_FLUSH;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         mode_ff  <= mode_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      mode_in       = mode_ff;
      req_tready    = 1'b0;
      cmd           = '0;
      cmd.div_sel   = DIV_SUM;
      cmd.mul_sel   = MUL_CROSS;
      cmd.emit_mode = mode_ff;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch_in = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!status.kind) begin
               state_in = ST_RS_GO;
            end else if (status.pending) begin
               mode_in  = EM_FLUSH;
               ret_in   = ST_FLUSH_DONE;
               state_in = ST_EDIV_GO;
            end else begin
               state_in = ST_FLUSH_DONE;
            end
         end
         ST_FLUSH_DONE: begin
            cmd.clear_stream = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_RS_GO: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DIV_START;
            state_in    = ST_RS_WAIT;
         end
         ST_RS_WAIT: begin
            if (status.div_done) begin
               cmd.load_rs = 1'b1;
               state_in    = ST_RE_GO;
            end
         end
         ST_RE_GO: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DIV_STOP;
            state_in    = ST_RE_WAIT;
         end
         ST_RE_WAIT: begin
            if (status.div_done) begin
               cmd.load_re = 1'b1;
               state_in    = ST_JUMP;
            end
         end
         ST_JUMP: begin
            if (status.cur_lt_rs && status.pending) begin
               mode_in  = EM_JUMP;
               ret_in   = ST_JUMP;
               state_in = ST_EDIV_GO;
            end else begin
               cmd.jump_cur = status.cur_lt_rs;
               state_in     = ST_LO;
            end
         end
         ST_LO: begin
            cmd.load_lo = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.re_gt_cur ? ST_MUL_CROSS : ST_MUL_FINAL;
         end
         ST_MUL_CROSS: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_CROSS;
            state_in    = ST_ACC_CROSS;
         end
         ST_ACC_CROSS: begin
            cmd.acc  = 1'b1;
            mode_in  = EM_CROSS;
            ret_in   = ST_ADVANCE;
            state_in = ST_EDIV_GO;
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = status.cross_err ? ST_IDLE : ST_CHECK;
         end
         ST_MUL_FINAL: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_FINAL;
            state_in    = ST_ACC_FINAL;
         end
         ST_ACC_FINAL: begin
            cmd.acc  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_EDIV_GO: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DIV_SUM;
            state_in    = ST_EDIV_WAIT;
         end
         ST_EDIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_EOUT;
            end
         end
         ST_EOUT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire
